@@ rtl/dsv_pkg.sv @@
// ----------------------------------------------------------------------------
// Date string validator package
// Character codes, field selector type and calendar helpers shared by the
// validator core and its port checker.
// ----------------------------------------------------------------------------
package dsv_pkg;

    localparam int CHAR_W     = 8;
    localparam int DAY_W      = 7;
    localparam int MONTH_W    = 7;
    localparam int YEAR_W     = 14;
    localparam int DIGIT_W    = 4;
    localparam int MLEN_W     = 5;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [DAY_W-1:0]   DAY_MAX     = 7'd31;
    localparam logic [MONTH_W-1:0] MONTH_MAX   = 7'd12;
    localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1000;
    localparam logic [YEAR_W-1:0]  YEAR_OFFSET = 14'd2000;
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;

    // Which date field the incoming digits belong to.
    typedef enum logic [2:0] {
        FIELD_DAY   = 3'b001,
        FIELD_MONTH = 3'b010,
        FIELD_YEAR  = 3'b100
    } field_t;

    // Number of days in a month; months outside 1..12 are rejected elsewhere.
    function automatic logic [MLEN_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
        logic [MLEN_W-1:0] len;
        begin
            case (month)
                7'd2:                    len = leap ? 5'd29 : 5'd28;
                7'd4, 7'd6, 7'd9, 7'd11: len = 5'd30;
                default:                 len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

@@ rtl/date_string_validator_core.sv @@
// ----------------------------------------------------------------------------
// Date string validator core
// Parses a day/month/year string one character per beat and reports whether
// it names a valid Gregorian date when the terminating NUL arrives.
// ----------------------------------------------------------------------------
// Result path: the result of a NUL beat is registered twice, first the NUL in
// the input register, then its verdict in the result register, which offers
// it until it is taken.
// Throughput: one character per cycle; the only thing that can stall the
// input is a NUL waiting behind an untaken result.
// Reset: synchronous, active low; clears the valid flags and the parse state.
// ----------------------------------------------------------------------------
module date_string_validator_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [dsv_pkg::CHAR_W-1:0]       s_char_code,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_date_valid,
    output logic [dsv_pkg::DAY_W-1:0]        m_day_out,
    output logic [dsv_pkg::MONTH_W-1:0]      m_month_out,
    output logic [dsv_pkg::YEAR_W-1:0]       m_year_out
);
    import dsv_pkg::*;

    // Input register stage.
    logic                 in_valid_reg;
    logic [CHAR_W-1:0]    char_reg;

    // Parse state.
    field_t               field_reg, field_next;
    logic [DAY_W-1:0]     day_reg, day_next;
    logic [MONTH_W-1:0]   month_reg, month_next;
    logic [YEAR_W-1:0]    year_reg, year_next;
    logic [1:0]           day_cnt_reg, day_cnt_next;
    logic [1:0]           month_cnt_reg, month_cnt_next;
    logic [2:0]           year_cnt_reg, year_cnt_next;
    logic                 fmt_err_reg, fmt_err_next;
    // The year digits are also kept in decimal form, most recent digit in
    // entry zero, so that the leap year test needs no division.
    logic [3:0][DIGIT_W-1:0] year_bcd_reg, year_bcd_next;

    // Result register stage.
    logic                 out_valid_reg;
    logic                 date_valid_reg;
    logic [DAY_W-1:0]     day_out_reg;
    logic [MONTH_W-1:0]   month_out_reg;
    logic [YEAR_W-1:0]    year_out_reg;

    logic                 is_nul;
    logic                 is_slash;
    logic                 is_digit;
    logic [DIGIT_W-1:0]   digit;
    logic                 advance;

    logic [YEAR_W-1:0]    year_adj;
    logic [1:0]           mod4_low;
    logic [1:0]           mod4_cent;
    logic                 cent_zero;
    logic                 leap;
    logic                 date_ok;

    // Decode of the character held in the input register.
    assign is_nul   = (char_reg == CHAR_NUL);
    assign is_slash = (char_reg == CHAR_SLASH);
    assign is_digit = (char_reg >= CHAR_ZERO) && (char_reg <= CHAR_NINE);
    assign digit    = DIGIT_W'(char_reg - CHAR_ZERO);

    // An ordinary character always moves on. A NUL needs the result register
    // to be empty or to be emptied in this same cycle.
    assign advance = in_valid_reg && (!is_nul || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Year as reported: years below 1000 get 2000 added, so two-digit years land in the 2000s.
    assign year_adj = (year_reg < YEAR_MIN) ? (year_reg + YEAR_OFFSET) : year_reg;

    // Leap year test on the decimal digits. The year mod 4 follows from the
    // last two digits, and the century mod 4 from the two digits before them.
    // Adding 2000 leaves both unchanged, so the raw digits serve.
    assign mod4_low  = 2'({year_bcd_reg[1][0], 1'b0}) + year_bcd_reg[0][1:0];
    assign mod4_cent = 2'({year_bcd_reg[3][0], 1'b0}) + year_bcd_reg[2][1:0];
    assign cent_zero = (year_bcd_reg[1] == '0) && (year_bcd_reg[0] == '0);
    assign leap      = (mod4_low == 2'd0) && (!cent_zero || (mod4_cent == 2'd0));

    // Final verdict for a completed string.
    always_comb begin
        date_ok = !fmt_err_reg
                  && (field_reg == FIELD_YEAR)
                  && ((year_cnt_reg == 3'd2) || (year_cnt_reg == 3'd4))
                  && (day_reg >= DAY_W'(1)) && (day_reg <= DAY_MAX)
                  && (month_reg >= MONTH_W'(1)) && (month_reg <= MONTH_MAX)
                  && (day_reg <= DAY_W'(month_len(month_reg, leap)));
    end

    // Next parse state for the character leaving the input register.
    always_comb begin
        field_next     = field_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        day_cnt_next   = day_cnt_reg;
        month_cnt_next = month_cnt_reg;
        year_cnt_next  = year_cnt_reg;
        fmt_err_next   = fmt_err_reg;
        year_bcd_next  = year_bcd_reg;

        if (is_nul) begin
            // The string is done; start clean for the next one.
            field_next     = FIELD_DAY;
            day_next       = '0;
            month_next     = '0;
            year_next      = '0;
            day_cnt_next   = '0;
            month_cnt_next = '0;
            year_cnt_next  = '0;
            fmt_err_next   = 1'b0;
            year_bcd_next  = '0;
        end else if (is_slash) begin
            // A slash inside the year field is ignored.
            unique case (field_reg)
                FIELD_DAY:   field_next = FIELD_MONTH;
                FIELD_MONTH: field_next = FIELD_YEAR;
                FIELD_YEAR:  field_next = FIELD_YEAR;
                default:     field_next = FIELD_DAY;
            endcase
        end else if (is_digit) begin
            // A digit beyond a field's limit flags the string and is dropped,
            // so the accumulators cannot overflow.
            unique case (field_reg)
                FIELD_DAY: begin
                    if (day_cnt_reg >= 2'd2) begin
                        fmt_err_next = 1'b1;
                    end else begin
                        day_next     = DAY_W'(day_reg * DAY_W'(10)) + DAY_W'(digit);
                        day_cnt_next = day_cnt_reg + 2'd1;
                    end
                end
                FIELD_MONTH: begin
                    if (month_cnt_reg >= 2'd2) begin
                        fmt_err_next = 1'b1;
                    end else begin
                        month_next     = MONTH_W'(month_reg * MONTH_W'(10))
                                         + MONTH_W'(digit);
                        month_cnt_next = month_cnt_reg + 2'd1;
                    end
                end
                FIELD_YEAR: begin
                    if (year_cnt_reg >= 3'd4) begin
                        fmt_err_next = 1'b1;
                    end else begin
                        year_next     = YEAR_W'(year_reg * YEAR_W'(10)) + YEAR_W'(digit);
                        year_cnt_next = year_cnt_reg + 3'd1;
                        year_bcd_next = {year_bcd_reg[2:0], digit};
                    end
                end
                default: begin
                    fmt_err_next = fmt_err_reg;
                end
            endcase
        end
    end

    // Input register: takes a beat whenever it is empty or being drained.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            char_reg <= s_char_code;
        end
    end

    // Parse state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg     <= FIELD_DAY;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            day_cnt_reg   <= '0;
            month_cnt_reg <= '0;
            year_cnt_reg  <= '0;
            fmt_err_reg   <= 1'b0;
            year_bcd_reg  <= '0;
        end else if (advance) begin
            field_reg     <= field_next;
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            day_cnt_reg   <= day_cnt_next;
            month_cnt_reg <= month_cnt_next;
            year_cnt_reg  <= year_cnt_next;
            fmt_err_reg   <= fmt_err_next;
            year_bcd_reg  <= year_bcd_next;
        end
    end

    // Result register: loaded by a NUL, emptied when the result beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && is_nul) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && is_nul) begin
            date_valid_reg <= date_ok;
            day_out_reg    <= day_reg;
            month_out_reg  <= month_reg;
            year_out_reg   <= year_adj;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_date_valid = date_valid_reg;
    assign m_day_out    = day_out_reg;
    assign m_month_out  = month_out_reg;
    assign m_year_out   = year_out_reg;

endmodule

@@ rtl/dsv_checker.sv @@
// ----------------------------------------------------------------------------
// Date string validator port checker
// Watches the result channel of the validator core and checks its beats.
// ----------------------------------------------------------------------------
module dsv_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_date_valid,
    input logic [dsv_pkg::DAY_W-1:0]     m_day_out,
    input logic [dsv_pkg::MONTH_W-1:0]   m_month_out,
    input logic [dsv_pkg::YEAR_W-1:0]    m_year_out
);
    import dsv_pkg::*;

    // A result beat that is not taken stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // Reset leaves no result beat behind.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // A date reported as valid has a day and a month in range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_date_valid |->
            (m_day_out >= DAY_W'(1)) && (m_day_out <= DAY_MAX)
            && (m_month_out >= MONTH_W'(1)) && (m_month_out <= MONTH_MAX))
        else $error("valid date with day or month out of range");

    // The reported year is always a four-digit year.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_year_out >= YEAR_MIN) && (m_year_out <= YEAR_MAX))
        else $error("reported year out of range");

endmodule

bind date_string_validator_core dsv_checker u_dsv_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_date_valid (m_date_valid),
    .m_day_out    (m_day_out),
    .m_month_out  (m_month_out),
    .m_year_out   (m_year_out)
);
